@@ hw/rtl/brlt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// brlt_pkg
// Shared constants, codes and controller/datapath interface types for the
// byte range lock table.
// ----------------------------------------------------------------------------
package brlt_pkg;

  localparam int TableSlots = 16;
  localparam int IdxW       = $clog2(TableSlots);
  localparam int CountW     = $clog2(TableSlots + 1);
  localparam int WcntW      = $clog2(TableSlots + 3);
  localparam int OffW       = 63;

  localparam logic [OffW-1:0] MaxOffset = {OffW{1'b1}};

  localparam logic       KindApply  = 1'b0;
  localparam logic       KindClear  = 1'b1;
  localparam logic [1:0] LockRead   = 2'd0;
  localparam logic [1:0] LockWrite  = 2'd1;
  localparam logic [1:0] LockUnlock = 2'd2;
  localparam logic [1:0] LockSpare  = 2'd3;

  localparam logic StatusDone     = 1'b0;
  localparam logic StatusRejected = 1'b1;

  typedef struct packed {
    logic load;
    logic pass_start;
    logic idx_rst;
    logic fetch;
    logic merge_eval;
    logic idx_inc;
    logic write_lo;
    logic write_hi;
    logic ins;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic idx_end;
    logic changed;
    logic is_lock;
    logic keep;
    logic hi_need;
  } sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/brlt_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// brlt_dpath
// Datapath: two table banks, request range registers, slot scan, merge and
// split compare logic, rebuild write port and result registers.
// ----------------------------------------------------------------------------
module brlt_dpath import brlt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              kind_i,
  input  logic [1:0]        lock_type_i,
  input  logic [OffW-1:0]   range_start_i,
  input  logic [OffW-1:0]   range_length_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              status_o,
  output logic [CountW-1:0] entry_count_o,
  output logic              table_empty_o
);

  logic              sel_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] idx_q;
  logic [WcntW-1:0]  wcnt_q;
  logic [TableSlots-1:0] used_q;
  logic              changed_q;
  logic              clear_q;
  logic [1:0]        type_q;
  logic [OffW-1:0]   s_q, e_q;
  logic [OffW-1:0]   cur_first_q, cur_last_q;
  logic              cur_wr_q, cur_used_q;
  logic              status_q, empty_q;
  logic [CountW-1:0] ecount_q;

  logic [OffW-1:0] first_q [2][TableSlots];
  logic [OffW-1:0] last_q  [2][TableSlots];
  logic            wr_q    [2][TableSlots];

  logic [OffW:0]   sum;
  logic [OffW-1:0] e_in;
  logic            meet, merge_hit, keep, hi_need, room, reject, wr_go;
  logic [OffW-1:0] wd_first, wd_last;
  logic            wd_wr;
  logic [CountW-1:0] count_new;

  assign sum  = {1'b0, range_start_i} + {1'b0, range_length_i} - {{OffW{1'b0}}, 1'b1};
  assign e_in = (range_length_i == '0 || sum[OffW]) ? MaxOffset : sum[OffW-1:0];

  assign meet      = (cur_last_q >= s_q) && (e_q >= cur_first_q);
  assign merge_hit = !cur_used_q && (cur_wr_q == type_q[0]) && meet;
  assign keep      = !cur_used_q && (!meet || (cur_first_q < s_q));
  assign hi_need   = !cur_used_q && meet && (cur_last_q > e_q);
  assign room      = wcnt_q < WcntW'(TableSlots);
  assign reject    = !clear_q && (wcnt_q > WcntW'(TableSlots));
  assign wr_go     = cmd_i.write_lo || cmd_i.write_hi || cmd_i.ins;
  assign count_new = clear_q ? '0 : (reject ? count_q : wcnt_q[CountW-1:0]);

  always_comb begin
    if (cmd_i.ins) begin
      wd_first = s_q;
      wd_last  = e_q;
      wd_wr    = type_q[0];
    end else if (cmd_i.write_hi) begin
      wd_first = e_q + OffW'(1);
      wd_last  = cur_last_q;
      wd_wr    = cur_wr_q;
    end else begin
      wd_first = cur_first_q;
      wd_last  = meet ? (s_q - OffW'(1)) : cur_last_q;
      wd_wr    = cur_wr_q;
    end
  end

  assign sts_o.idx_end  = idx_q >= count_q;
  assign sts_o.changed  = changed_q;
  assign sts_o.is_lock  = !type_q[1];
  assign sts_o.keep     = keep;
  assign sts_o.hi_need  = hi_need;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q     <= 1'b0;
      count_q   <= '0;
      idx_q     <= '0;
      wcnt_q    <= '0;
      used_q    <= '0;
      changed_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        used_q <= '0;
        wcnt_q <= '0;
        idx_q  <= '0;
      end
      if (cmd_i.pass_start) begin
        changed_q <= 1'b0;
        idx_q     <= '0;
      end
      if (cmd_i.idx_rst) begin
        idx_q <= '0;
      end
      if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CountW'(1);
      end
      if (cmd_i.merge_eval && merge_hit) begin
        used_q[idx_q[IdxW-1:0]] <= 1'b1;
        changed_q <= 1'b1;
      end
      if (wr_go) begin
        wcnt_q <= wcnt_q + WcntW'(1);
      end
      if (cmd_i.commit) begin
        count_q <= count_new;
        if (!clear_q && !reject) begin
          sel_q <= ~sel_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      clear_q <= kind_i;
      type_q  <= lock_type_i;
      s_q     <= range_start_i;
      e_q     <= e_in;
    end
    if (cmd_i.merge_eval && merge_hit) begin
      if (cur_first_q < s_q) begin
        s_q <= cur_first_q;
      end
      if (cur_last_q > e_q) begin
        e_q <= cur_last_q;
      end
    end
    if (cmd_i.fetch) begin
      cur_first_q <= first_q[sel_q][idx_q[IdxW-1:0]];
      cur_last_q  <= last_q[sel_q][idx_q[IdxW-1:0]];
      cur_wr_q    <= wr_q[sel_q][idx_q[IdxW-1:0]];
      cur_used_q  <= used_q[idx_q[IdxW-1:0]];
    end
    if (cmd_i.commit) begin
      status_q <= reject ? StatusRejected : StatusDone;
      ecount_q <= count_new;
      empty_q  <= count_new == '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_go && room) begin
      first_q[~sel_q][wcnt_q[IdxW-1:0]] <= wd_first;
      last_q[~sel_q][wcnt_q[IdxW-1:0]]  <= wd_last;
      wr_q[~sel_q][wcnt_q[IdxW-1:0]]    <= wd_wr;
    end
  end

  assign status_o      = status_q;
  assign entry_count_o = ecount_q;
  assign table_empty_o = empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(TableSlots))
    else $error("held count above table size");

  a_wcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q <= WcntW'(TableSlots + 2))
    else $error("rebuild count above table size plus two");

  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && reject |=> count_q == $past(count_q) && sel_q == $past(sel_q))
    else $error("rejected request changed the table");

  a_used_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.merge_eval |-> idx_q < count_q)
    else $error("merge evaluated past the held entries");

endmodule
`default_nettype wire

@@ hw/rtl/brlt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// brlt_ctrl
// Controller: sequences merge passes, the split and rebuild pass, insert
// and commit; owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module brlt_ctrl import brlt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  logic kind_i,
  input  logic [1:0] lock_type_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StMrgRd, StMrgEv, StSplRd, StSplEv, StSplHi, StIns, StFin
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = (out_valid_q && !out_ready_i);
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (kind_i == KindClear) begin
            state_d = StFin;
          end else if (!lock_type_i[1]) begin
            cmd_o.pass_start = 1'b1;
            state_d = StMrgRd;
          end else begin
            state_d = StSplRd;
          end
        end
      end
      StMrgRd: begin
        if (sts_i.idx_end) begin
          if (sts_i.changed) begin
            cmd_o.pass_start = 1'b1;
          end else begin
            cmd_o.idx_rst = 1'b1;
            state_d = StSplRd;
          end
        end else begin
          cmd_o.fetch = 1'b1;
          state_d = StMrgEv;
        end
      end
      StMrgEv: begin
        cmd_o.merge_eval = 1'b1;
        cmd_o.idx_inc    = 1'b1;
        state_d = StMrgRd;
      end
      StSplRd: begin
        if (sts_i.idx_end) begin
          state_d = sts_i.is_lock ? StIns : StFin;
        end else begin
          cmd_o.fetch = 1'b1;
          state_d = StSplEv;
        end
      end
      StSplEv: begin
        cmd_o.write_lo = sts_i.keep;
        if (sts_i.hi_need) begin
          state_d = StSplHi;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = StSplRd;
        end
      end
      StSplHi: begin
        cmd_o.write_hi = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d = StSplRd;
      end
      StIns: begin
        cmd_o.ins = 1'b1;
        state_d = StFin;
      end
      StFin: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = out_valid_q;

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !out_valid_q || out_ready_i)
    else $error("result overwritten before transfer");

  a_clear_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle && in_valid_i && kind_i == KindClear |=> state_q == StFin)
    else $error("clear request did not go straight to commit");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.write_lo, cmd_o.write_hi, cmd_o.ins}) <= 1)
    else $error("more than one table write in a cycle");

endmodule
`default_nettype wire

@@ hw/rtl/byte_range_lock_table_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// byte_range_lock_table_core
// Table of disjoint byte ranges held as read or write locks, with merge of
// same-type overlaps, split of other-type overlaps, range unlock and table clear.
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid_i/in_ready_o carries kind, lock type, start and
//   length; one result (status, entry count, table empty) per request on
//   out_valid_o/out_ready_i
//   requests are worked one at a time; in_ready_o is high only when idle
//   a clear goes straight to commit; a lock request runs merge passes
//   (passes repeat until one merges nothing), then a split pass and an
//   insert, an unlock only the split pass; the slot scan reads the held
//   entries one at a time from the active table bank
//   the new table is built in the other bank and swapped in on commit; a
//   rejected request leaves the active bank untouched
//   reset empties the table at once, no clearing pass
//   a stalled receiver holds the result; the next request may be taken and
//   worked, and it waits at commit until the held result is transferred
// ----------------------------------------------------------------------------
module byte_range_lock_table_core import brlt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [1:0]        lock_type_i,
  input  logic [OffW-1:0]   range_start_i,
  input  logic [OffW-1:0]   range_length_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              status_o,
  output logic [CountW-1:0] entry_count_o,
  output logic              table_empty_o
);

  cmd_t cmd;
  sts_t sts;

  brlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_i      (kind_i),
    .lock_type_i (lock_type_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  brlt_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .kind_i         (kind_i),
    .lock_type_i    (lock_type_i),
    .range_start_i  (range_start_i),
    .range_length_i (range_length_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o),
    .table_empty_o  (table_empty_o)
  );

endmodule
`default_nettype wire
